// ===== hw/rtl/sfx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfx_pkg
// Shared types and constants of the speed frame exchanger.
// ----------------------------------------------------------------------------
package sfx_pkg;

  localparam int FRAME_BYTES = 18;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int IN_DATA_W   = 136;
  localparam int OUT_DATA_W  = 48;

  localparam logic [7:0]  HEADER_BYTE      = 8'hBB;
  localparam logic [24:0] ANGLE_GAIN_Q16   = 25'd20860757;
  localparam logic [35:0] ANGLE_OFFSET_Q16 = 36'd32768000;
  localparam logic [15:0] ANGLE_RESET      = 16'd1000;
  localparam logic [15:0] SAT16            = 16'hFFFF;
  localparam logic [63:0] ANGLE_LIMIT      = 64'd1024;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        frame_start;
    logic [63:0] speed_left;
    logic [63:0] speed_right;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        frame_done;
    logic        check_ok;
    logic [15:0] speed_command;
    logic [15:0] angle_command;
  } result_t;

endpackage

// ===== hw/rtl/sfx_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfx_in_reg
// Input register stage: holds one accepted item until the core takes it.
// ----------------------------------------------------------------------------
module sfx_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfx_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output sfx_pkg::in_item_t out_item
);

  logic              valid;
  sfx_pkg::in_item_t item;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// ===== hw/rtl/sfx_frame_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfx_frame_core
// Frame state, byte sequencing, checksums and command decode for one item.
// ----------------------------------------------------------------------------
module sfx_frame_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  sfx_pkg::in_item_t item,
  output sfx_pkg::result_t  result
);

  logic [sfx_pkg::POS_W-1:0] byte_position;
  logic [63:0]               left_latch;
  logic [63:0]               right_latch;
  logic [7:0]                tx_parity;
  logic [7:0]                rx_parity;
  logic [63:0]               rx_speed_accum;
  logic [63:0]               rx_angle_accum;
  logic [15:0]               held_speed;
  logic [15:0]               held_angle;

  logic [sfx_pkg::POS_W-1:0] pos;
  logic [sfx_pkg::POS_W-1:0] byte_position_next;
  logic                      first;
  logic                      last;
  logic [63:0]               lat_l;
  logic [63:0]               lat_r;
  logic [7:0]                tp;
  logic [7:0]                rp;
  logic [63:0]               sa;
  logic [63:0]               aa;
  logic [2:0]                idx_l;
  logic [2:0]                idx_r;
  logic [7:0]                tx;
  logic [63:0]               rx_speed_accum_next;
  logic [63:0]               rx_angle_accum_next;
  logic [7:0]                tx_parity_next;
  logic [7:0]                rx_parity_next;
  logic                      ok;
  logic [15:0]               speed_sat;
  logic [35:0]               prod;
  logic [19:0]               angle_q;
  logic [15:0]               angle_sat;
  logic [15:0]               held_speed_next;
  logic [15:0]               held_angle_next;

  always_comb begin
    pos   = item.frame_start ? '0 : byte_position;
    first = (pos == '0);
    last  = (pos >= sfx_pkg::POS_W'(sfx_pkg::FRAME_BYTES - 1));
    lat_l = item.frame_start ? item.speed_left  : left_latch;
    lat_r = item.frame_start ? item.speed_right : right_latch;
    // a new frame starts from clean parities and accumulators
    tp    = first ? '0 : tx_parity;
    rp    = first ? '0 : rx_parity;
    sa    = first ? '0 : rx_speed_accum;
    aa    = first ? '0 : rx_angle_accum;
    idx_l = 3'(pos - sfx_pkg::POS_W'(1));
    idx_r = 3'(pos - sfx_pkg::POS_W'(9));

    tx                  = sfx_pkg::HEADER_BYTE;
    rx_speed_accum_next = sa;
    rx_angle_accum_next = aa;
    if (last) begin
      tx = tp;
    end else if (first) begin
      tx = sfx_pkg::HEADER_BYTE;
    end else if (pos <= sfx_pkg::POS_W'(8)) begin
      tx = lat_l[8*idx_l +: 8];
      rx_speed_accum_next[8*idx_l +: 8] = sa[8*idx_l +: 8] | item.rx_byte;
    end else begin
      tx = lat_r[8*idx_r +: 8];
      rx_angle_accum_next[8*idx_r +: 8] = aa[8*idx_r +: 8] | item.rx_byte;
    end

    tx_parity_next     = last ? tp : (tp ^ tx);
    rx_parity_next     = last ? rp : (rp ^ item.rx_byte);
    byte_position_next = last ? '0 : (pos + sfx_pkg::POS_W'(1));
    ok                 = last && (item.rx_byte == rp);

    speed_sat = (sa > 64'(sfx_pkg::SAT16)) ? sfx_pkg::SAT16 : sa[15:0];
    // q16 scaling: a*1000/pi + 500, only meaningful for a up to the limit
    prod      = 36'(aa[10:0]) * 36'(sfx_pkg::ANGLE_GAIN_Q16) + sfx_pkg::ANGLE_OFFSET_Q16;
    angle_q   = prod[35:16];
    angle_sat = ((aa > sfx_pkg::ANGLE_LIMIT) || (angle_q > 20'(sfx_pkg::SAT16))) ?
                sfx_pkg::SAT16 : angle_q[15:0];

    held_speed_next = ok ? speed_sat : held_speed;
    held_angle_next = ok ? angle_sat : held_angle;

    result.tx_byte       = tx;
    result.frame_done    = last;
    result.check_ok      = ok;
    result.speed_command = held_speed_next;
    result.angle_command = held_angle_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      left_latch     <= '0;
      right_latch    <= '0;
      tx_parity      <= '0;
      rx_parity      <= '0;
      rx_speed_accum <= '0;
      rx_angle_accum <= '0;
      held_speed     <= '0;
      held_angle     <= sfx_pkg::ANGLE_RESET;
    end else if (fire) begin
      byte_position  <= byte_position_next;
      left_latch     <= lat_l;
      right_latch    <= lat_r;
      tx_parity      <= tx_parity_next;
      rx_parity      <= rx_parity_next;
      rx_speed_accum <= rx_speed_accum_next;
      rx_angle_accum <= rx_angle_accum_next;
      held_speed     <= held_speed_next;
      held_angle     <= held_angle_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= sfx_pkg::POS_W'(sfx_pkg::FRAME_BYTES - 1))
    else $error("byte position out of frame");

  a_angle_only_on_good_frame: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (held_angle != $past(held_angle))) |->
      $past(fire && result.frame_done && result.check_ok))
    else $error("angle command changed without a good frame");

  a_speed_only_on_good_frame: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (held_speed != $past(held_speed))) |->
      $past(fire && result.frame_done && result.check_ok))
    else $error("speed command changed without a good frame");

endmodule

// ===== hw/rtl/sfx_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfx_out_reg
// Result register: holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module sfx_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sfx_pkg::result_t in_result,
  output logic             out_valid,
  input  logic             out_ready,
  output sfx_pkg::result_t out_result
);

  logic             valid;
  sfx_pkg::result_t result;

  assign in_ready   = !valid || out_ready;
  assign out_valid  = valid;
  assign out_result = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      result <= in_result;
    end
  end

endmodule

// ===== hw/rtl/spi_speed_frame_exchanger.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_speed_frame_exchanger
// Slave side of an 18-byte full-duplex SPI speed/angle frame, one byte per item.
// ----------------------------------------------------------------------------
// Each item is one SPI byte slot: the received byte plus a frame-start flag
// and the two wheel speeds to latch. Each item yields exactly one result item
// with the byte to send back, a frame-done mark (tlast), the checksum verdict
// and the held speed and angle commands. The block takes one item per clock
// while the output side is ready; each item passes the input register and
// then the result register, with all frame logic and the 11x25 angle multiply
// in between. Both registers pass back-pressure, so stalls on the output side
// are absorbed without losing or repeating items.
module spi_speed_frame_exchanger (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // rx_byte[7:0], speed_left[71:8], speed_right[135:72]
  input  logic [sfx_pkg::IN_DATA_W-1:0]    s_tdata,
  // frame_start
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // tx_byte[7:0], check_ok[8], speed_command[24:9], angle_command[40:25], zero fill
  output logic [sfx_pkg::OUT_DATA_W-1:0]   m_tdata,
  // frame_done
  output logic                             m_tlast
);

  sfx_pkg::in_item_t s_item;
  sfx_pkg::in_item_t core_item;
  sfx_pkg::result_t  core_result;
  sfx_pkg::result_t  m_result;
  logic              core_valid;
  logic              core_ready;

  always_comb begin
    s_item.rx_byte     = s_tdata[7:0];
    s_item.frame_start = s_tuser;
    s_item.speed_left  = s_tdata[71:8];
    s_item.speed_right = s_tdata[135:72];
  end

  sfx_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (s_item),
    .out_valid (core_valid),
    .out_ready (core_ready),
    .out_item  (core_item)
  );

  sfx_frame_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (core_valid && core_ready),
    .item   (core_item),
    .result (core_result)
  );

  sfx_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (core_valid),
    .in_ready   (core_ready),
    .in_result  (core_result),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (m_result)
  );

  assign m_tdata = {7'b0, m_result.angle_command, m_result.speed_command,
                    m_result.check_ok, m_result.tx_byte};
  assign m_tlast = m_result.frame_done;

  a_no_output_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !m_tvalid)
    else $error("result item valid right after reset");

  a_check_only_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> !m_tdata[8])
    else $error("check_ok set outside the last byte of a frame");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SPI speed frame exchanger. A short directed
// table opens the run, then random frames follow, most of them well formed
// with random speeds and angles, the rest truncated, broken or plain noise.
// Results are compared per field to typed table rows, else a frame model.
// ----------------------------------------------------------------------------
module tb;
  import sfx_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 120;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [63:0] ONES = '1;

  typedef struct {
    logic [7:0]  rx;
    logic        start;
    logic [63:0] left;
    logic [63:0] right;
    bit          typed;
    result_t     want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tlast;

  spi_speed_frame_exchanger dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  stim_row_t stim_q[$];
  result_t   pending_results[$];
  int        accepted_items = 0;
  int        errors = 0;
  int        idle_cycles = 0;

  // frame model state
  logic [4:0]  slot = '0;
  logic [63:0] left_held = '0;
  logic [63:0] right_held = '0;
  logic [7:0]  tx_xor = '0;
  logic [7:0]  rx_xor = '0;
  logic [63:0] speed_gather = '0;
  logic [63:0] angle_gather = '0;
  logic [15:0] speed_cmd = '0;
  logic [15:0] angle_cmd = ANGLE_RESET;

  function automatic logic [15:0] angle_to_code(logic [63:0] a);
    logic [63:0] scaled;
    if (a > ANGLE_LIMIT) return SAT16;
    scaled = (a * 64'(ANGLE_GAIN_Q16) + 64'(ANGLE_OFFSET_Q16)) >> 16;
    return (scaled > 64'(SAT16)) ? SAT16 : scaled[15:0];
  endfunction

  function automatic result_t exchange_byte(logic [7:0] rx, logic start,
                                            logic [63:0] left, logic [63:0] right);
    result_t r;
    logic [4:0] p;
    r = '0;
    if (start) begin
      slot = '0;
      left_held = left;
      right_held = right;
    end
    p = slot;
    if (p == 0) begin
      tx_xor = '0;
      rx_xor = '0;
      speed_gather = '0;
      angle_gather = '0;
    end
    if (p >= FRAME_BYTES - 1) begin
      r.tx_byte = tx_xor;
      r.frame_done = 1'b1;
      r.check_ok = (rx == rx_xor);
      if (r.check_ok) begin
        speed_cmd = (speed_gather > 64'(SAT16)) ? SAT16 : speed_gather[15:0];
        angle_cmd = angle_to_code(angle_gather);
      end
      slot = '0;
    end else begin
      if (p == 0) begin
        r.tx_byte = HEADER_BYTE;
      end else if (p <= 8) begin
        r.tx_byte = left_held[8*(p-1) +: 8];
        speed_gather[8*(p-1) +: 8] = rx;
      end else begin
        r.tx_byte = right_held[8*(p-9) +: 8];
        angle_gather[8*(p-9) +: 8] = rx;
      end
      tx_xor ^= r.tx_byte;
      rx_xor ^= rx;
      slot = p + 1'b1;
    end
    r.speed_command = speed_cmd;
    r.angle_command = angle_cmd;
    return r;
  endfunction

  task automatic add_row(logic [7:0] rx, logic start, logic [63:0] left,
                         logic [63:0] right, bit typed, result_t want);
    stim_row_t row;
    row.rx = rx;
    row.start = start;
    row.left = left;
    row.right = right;
    row.typed = typed;
    row.want = want;
    stim_q.push_back(row);
  endtask

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return ONES;
      2: return 64'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] pick_speed();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 64'd65535;
      2: return 64'd65536;
      3: return {$urandom, $urandom};
      4: return ONES;
      default: return 64'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [63:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 64'd1024;
      2: return 64'd1025;
      3: return {$urandom, $urandom};
      4: return 64'($urandom_range(0, 5000));
      default: return 64'($urandom_range(0, 1100));
    endcase
  endfunction

  // one random frame: mostly well formed, sometimes cut short, corrupted or noise
  task automatic add_random_frame();
    logic [7:0]  bytes [FRAME_BYTES];
    logic [63:0] spd;
    logic [63:0] ang;
    logic [7:0]  sum;
    int kind;
    int len;
    logic first_start;
    spd = pick_speed();
    ang = pick_angle();
    kind = $urandom_range(0, 9);
    bytes[0] = 8'($urandom);
    for (int k = 0; k < 8; k++) begin
      bytes[1+k] = spd[8*k +: 8];
      bytes[9+k] = ang[8*k +: 8];
    end
    sum = '0;
    for (int k = 0; k < FRAME_BYTES - 1; k++) sum ^= bytes[k];
    bytes[FRAME_BYTES-1] = sum;
    len = FRAME_BYTES;
    if (kind == 7) begin
      bytes[FRAME_BYTES-1] = sum ^ 8'(1 << $urandom_range(0, 7));
    end else if (kind == 8) begin
      len = $urandom_range(1, FRAME_BYTES - 1);
    end else if (kind == 9) begin
      for (int k = 0; k < FRAME_BYTES; k++) bytes[k] = 8'($urandom);
      len = $urandom_range(1, FRAME_BYTES);
    end
    first_start = ($urandom_range(0, 4) != 0);
    for (int k = 0; k < len; k++) begin
      add_row(bytes[k], (k == 0) ? first_start : 1'b0, pick_word(), pick_word(),
              1'b0, '0);
    end
  endtask

  function automatic result_t typed_result(logic [7:0] tx, logic done, logic ok,
                                           logic [15:0] spd, logic [15:0] ang);
    result_t r;
    r.tx_byte = tx;
    r.frame_done = done;
    r.check_ok = ok;
    r.speed_command = spd;
    r.angle_command = ang;
    return r;
  endfunction

  task automatic build_stimulus();
    result_t idle_hdr;
    idle_hdr = typed_result(HEADER_BYTE, 1'b0, 1'b0, 16'd0, ANGLE_RESET);
    // first byte after reset opens a frame without a start mark
    add_row(8'h00, 1'b0, ONES, ONES, 1'b1, idle_hdr);
    // start in the middle of a frame drops it and latches the speeds
    add_row(8'hFF, 1'b1, ONES, '0, 1'b1, idle_hdr);
    for (int k = 0; k < 8; k++)
      add_row(8'hFF, 1'b0, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1,
              typed_result(8'hFF, 1'b0, 1'b0, 16'd0, ANGLE_RESET));
    // angle of exactly 1024, speed all ones: both commands saturate
    for (int k = 0; k < 8; k++)
      add_row((k == 1) ? 8'h04 : 8'h00, 1'b0, '0, ONES, 1'b1,
              typed_result(8'h00, 1'b0, 1'b0, 16'd0, ANGLE_RESET));
    add_row(8'hFB, 1'b0, '0, '0, 1'b1,
            typed_result(HEADER_BYTE, 1'b1, 1'b1, SAT16, SAT16));
    // after a finished frame the next byte begins one on its own
    add_row(8'h12, 1'b0, ONES, ONES, 1'b0, '0);
    add_row(8'h34, 1'b1, 64'h0123_4567_89AB_CDEF, ONES, 1'b0, '0);
    add_row(8'h56, 1'b0, '0, '0, 1'b0, '0);
    add_row(8'h78, 1'b0, '0, '0, 1'b0, '0);
    add_row(8'h9A, 1'b1, 64'hFEDC_BA98_7654_3210, 64'h0F0F_0F0F_F0F0_F0F0, 1'b0, '0);
    add_row(8'hBC, 1'b0, '0, '0, 1'b0, '0);
    while (stim_q.size() < 25 + RANDOM_ITEMS) add_random_frame();
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // scoreboard: predict on input handshake, compare on output handshake
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        want = exchange_byte(s_tdata[7:0], s_tuser, s_tdata[71:8], s_tdata[135:72]);
        if (stim_q[accepted_items].typed) want = stim_q[accepted_items].want;
        pending_results.push_back(want);
        accepted_items++;
      end
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no expectation, tdata %0h", $time, m_tdata);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("tx_byte", want.tx_byte, m_tdata[7:0]);
          check_field("frame_done", want.frame_done, m_tlast);
          check_field("check_ok", want.check_ok, m_tdata[8]);
          check_field("speed_command", want.speed_command, m_tdata[24:9]);
          check_field("angle_command", want.angle_command, m_tdata[40:25]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int gap;
    int taken;
    bit burst;
    taken = 0;
    burst = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 6);
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  initial begin
    int gap;
    bit burst;
    burst = 1'b0;
    build_stimulus();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (stim_q[i]) begin
      if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= {stim_q[i].right, stim_q[i].left, stim_q[i].rx};
      s_tuser  <= stim_q[i].start;
      do @(posedge clk); while (!s_tready);
    end
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== spi_speed_frame_exchanger.f =====
hw/rtl/sfx_pkg.sv
hw/rtl/sfx_in_reg.sv
hw/rtl/sfx_frame_core.sv
hw/rtl/sfx_out_reg.sv
hw/rtl/spi_speed_frame_exchanger.sv
dv/tb.sv
